// ----- design/sine_wave_synthesizer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sine wave synthesizer unit
// Concurrent property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SINE_WAVE_SYNTHESIZER_UNIT_ASSERT_SVH
`define SINE_WAVE_SYNTHESIZER_UNIT_ASSERT_SVH

// Same-cycle implication, skipped while reset is asserted.
`define SWSU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, evaluated during reset too.
`define SWSU_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/sws_pkg.sv -----
// ----------------------------------------------------------------------------
// sws_pkg
// Shared constants, register codes and quarter-wave table math.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int AMP_BITS      = 15;
    localparam logic [AMP_BITS-1:0] AMP_RESET = 15'd32767;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PHASE_STEP   = 2'd0,
        CFG_PHASE_OFFSET = 2'd1,
        CFG_AMPLITUDE    = 2'd2
    } t_cfg_idx;

    // round(pi/2 * 2^30)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_HALF    = 64'd1 << 29;

    // (2n)(2n+1) for the eight Taylor terms
    localparam logic [63:0] TAYLOR_DIV [1:8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // Q30 sine by a nine-term series; elaboration time only.
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x + Q30_HALF) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 8; n++) begin
            term = (term * x2 + Q30_HALF) >> 30;
            term = term / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Quarter-wave entry k: round(peak * sin(pi/2 * k / 2^table_bits)).
    function automatic logic [63:0] qtr_sine(input int table_bits, input int sample_bits,
                                             input logic [63:0] k);
        logic [63:0] peak;
        logic [63:0] x;
        logic [63:0] v;
        peak = (64'd1 << (sample_bits - 1)) - 64'd1;
        x    = (HALF_PI_Q30 * k + ((64'd1 << table_bits) >> 1)) >> table_bits;
        v    = (sine_q30(x) * peak + Q30_HALF) >> 30;
        if (v > peak) begin
            v = peak;
        end
        return v;
    endfunction

endpackage

// ----- design/sws_if.sv -----
// ----------------------------------------------------------------------------
// sws_in_if / sws_out_if
// Valid/ready channels for the restart request and the output sample.
// ----------------------------------------------------------------------------
interface sws_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface sws_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ----- design/sws_phase.sv -----
// ----------------------------------------------------------------------------
// sws_phase
// Phase step/offset registers, phase accumulator and table index stage.
// ----------------------------------------------------------------------------
module sws_phase
    import sws_pkg::*;
#(
    parameter int PHASE_BITS = 32,
    parameter int TABLE_BITS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_en,
    input  logic                      i_accept,
    input  logic                      i_restart,
    output logic [TABLE_BITS+1:0]     o_idx
);

    logic [PHASE_BITS-1:0] r_step;
    logic [PHASE_BITS-1:0] r_offset;
    logic [PHASE_BITS-1:0] r_acc;
    logic [PHASE_BITS-1:0] n_acc;
    logic [PHASE_BITS-1:0] acc_cur;
    logic [PHASE_BITS-1:0] phase;
    logic [TABLE_BITS+1:0] r_idx;

    // restart clears the accumulator before this sample is formed
    assign acc_cur = i_restart ? '0 : r_acc;
    assign phase   = acc_cur + r_offset;
    assign n_acc   = acc_cur + r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_offset <= '0;
            r_acc    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_PHASE_STEP:   r_step   <= PHASE_BITS'(i_cfg_data);
                    CFG_PHASE_OFFSET: r_offset <= PHASE_BITS'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx <= phase[PHASE_BITS-1 -: TABLE_BITS+2];
        end
    end

    assign o_idx = r_idx;

endmodule

// ----- design/sws_rom.sv -----
// ----------------------------------------------------------------------------
// sws_rom
// Quarter-wave table lookup with quadrant mirroring; registered read.
// ----------------------------------------------------------------------------
module sws_rom
    import sws_pkg::*;
#(
    parameter int TABLE_BITS  = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [TABLE_BITS+1:0]  i_idx,
    output logic [SAMPLE_BITS-2:0] o_mag,
    output logic                   o_neg
);

    localparam int QTR = 1 << TABLE_BITS;
    localparam logic [TABLE_BITS:0] QTR_ADDR = (TABLE_BITS+1)'(QTR);

    typedef logic [SAMPLE_BITS-2:0] t_rom [0:QTR];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k <= QTR; k++) begin
            rom[k] = (SAMPLE_BITS-1)'(qtr_sine(TABLE_BITS, SAMPLE_BITS, 64'(k)));
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [TABLE_BITS-1:0]  k;
    logic [1:0]             quad;
    logic [TABLE_BITS:0]    addr;
    logic [SAMPLE_BITS-2:0] r_mag;
    logic                   r_neg;

    assign k    = i_idx[TABLE_BITS-1:0];
    assign quad = i_idx[TABLE_BITS+1:TABLE_BITS];
    // odd quadrants walk the table backwards
    assign addr = quad[0] ? (QTR_ADDR - {1'b0, k}) : {1'b0, k};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= ROM[addr];
            r_neg <= quad[1];
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

// ----- design/sws_scale.sv -----
// ----------------------------------------------------------------------------
// sws_scale
// Amplitude register, amplitude multiply with rounding, sign and output reg.
// ----------------------------------------------------------------------------
module sws_scale
    import sws_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                          i_en,
    input  logic [SAMPLE_BITS-2:0]        i_mag,
    input  logic                          i_neg,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    localparam int MAG_BITS  = SAMPLE_BITS - 1;
    localparam int PROD_BITS = AMP_BITS + MAG_BITS;
    localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (AMP_BITS - 1);

    logic [AMP_BITS-1:0]           r_amp;
    logic [PROD_BITS-1:0]          prod;
    logic [MAG_BITS-1:0]           mag_scaled;
    logic signed [SAMPLE_BITS-1:0] n_sample;
    logic signed [SAMPLE_BITS-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp <= AMP_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_AMPLITUDE: r_amp <= i_cfg_data[AMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // round half up on the magnitude, then apply the sign
    assign prod       = PROD_BITS'(r_amp) * PROD_BITS'(i_mag);
    assign mag_scaled = MAG_BITS'((prod + ROUND_HALF) >> AMP_BITS);
    assign n_sample   = i_neg ? ('0 - $signed({1'b0, mag_scaled}))
                              : $signed({1'b0, mag_scaled});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

// ----- design/sine_wave_synthesizer_unit.sv -----
// ----------------------------------------------------------------------------
// sine_wave_synthesizer_unit
// Each accepted request passes the three register stages (phase, table read, scale)
// to the output. Throughput: one sample per cycle while the output is ready; each
// stage advances whenever the stage after it is empty or moving.
// Reset: accumulator, step and offset clear, amplitude goes to 32767, pipe empties.
// ----------------------------------------------------------------------------
module sine_wave_synthesizer_unit
    import sws_pkg::*;
#(
    parameter int PHASE_BITS  = 32,
    parameter int TABLE_BITS  = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    sws_in_if.sink                   i_in_if,
    sws_out_if.source                o_out_if
);

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic en1;
    logic en2;
    logic en3;
    logic accept;

    logic [TABLE_BITS+1:0]  idx;
    logic [SAMPLE_BITS-2:0] mag;
    logic                   neg;

    // a stage may load when it is empty or its content moves on
    assign en3    = !r_v3 || o_out_if.ready;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign accept = en1 && i_in_if.valid;

    assign i_in_if.ready  = en1;
    assign o_out_if.valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_if.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    sws_phase #(
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_phase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_en       (en1),
        .i_accept   (accept),
        .i_restart  (i_in_if.restart),
        .o_idx      (idx)
    );

    sws_rom #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rom (
        .i_clk (i_clk),
        .i_en  (en2),
        .i_idx (idx),
        .o_mag (mag),
        .o_neg (neg)
    );

    sws_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_en       (en3),
        .i_mag      (mag),
        .i_neg      (neg),
        .o_sample   (o_out_if.sample)
    );

endmodule

// ----- design/sws_checker.sv -----
// ----------------------------------------------------------------------------
// sws_checker
// Port-level checks for the sine wave synthesizer unit, bound to the top.
// ----------------------------------------------------------------------------
`include "sine_wave_synthesizer_unit_assert.svh"

module sws_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_out_sample
);

    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    `SWSU_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !i_out_valid, "output valid after reset")
    `SWSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n && i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_sample), "stalled sample changed")
    `SWSU_ASSERT_SAME(a_no_bubble, i_clk, i_rst_n, !i_out_valid || i_out_ready, i_in_ready, "input stalled with output free")
    `SWSU_ASSERT_SAME(a_sample_range, i_clk, i_rst_n, i_out_valid, i_out_sample != MOST_NEG, "sample out of range")

endmodule

bind sine_wave_synthesizer_unit sws_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_sws_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in_if.ready),
    .i_out_valid  (o_out_if.valid),
    .i_out_ready  (o_out_if.ready),
    .i_out_sample (o_out_if.sample)
);
